// File: sv/brt_pkg.sv
// Shared types, codes and defaults for the beam request table.
package brt_pkg;

  localparam int unsigned DefTableDepth = 64;
  localparam int unsigned DefSections   = 128;

  localparam int unsigned SecW  = 7;
  localparam int unsigned BeamW = 20;
  localparam int unsigned ReqW  = 16;

  // Item modes.
  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_CLEAR   = 3'd1;
  localparam logic [2:0] MODE_DISCARD = 3'd2;
  localparam logic [2:0] MODE_SYNC_NEW = 3'd3;
  localparam logic [2:0] MODE_SYNC_ADJ = 3'd4;
  localparam logic [2:0] MODE_SYNC_KEEP = 3'd5;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_SEC  = 2'd1;
  localparam logic [1:0] STAT_BAD_BEAM = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_NUM_SECTIONS = 1'b0;
  localparam logic CFG_MAX_BEAM     = 1'b1;

  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [BeamW-1:0] beam;
    logic [ReqW-1:0]  req;
  } brt_entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_MERGE,
    CMD_CLEAR,
    CMD_SHIFT
  } brt_cmd_e;

  typedef struct packed {
    brt_cmd_e   cmd;
    logic       retain;
    brt_entry_t item;
  } brt_ctrl_t;

endpackage

// File: sv/brt_cell.sv
// One slot of the sorted entry chain: holds an entry and moves it to or from its neighbours.
module brt_cell
  import brt_pkg::*;
(
  input  logic        clk_i,
  input  brt_ctrl_t   ctrl_i,
  input  logic        valid_i,
  input  logic        is_tail_i,
  input  brt_entry_t  head_i,
  input  brt_entry_t  prev_i,
  input  logic        prev_gt_i,
  input  brt_entry_t  next_i,
  output brt_entry_t  data_o,
  output logic        gt_o,
  output logic        hit_o,
  output logic        hit_zero_o,
  output logic [ReqW-1:0] hit_req_o
);

  brt_entry_t data_q, data_d;
  logic [ReqW-1:0] merged;

  // Order is by beam index first, then section.
  assign gt_o  = !valid_i ||
                 ({data_q.beam, data_q.sec} > {ctrl_i.item.beam, ctrl_i.item.sec});
  assign hit_o = valid_i && data_q.beam == ctrl_i.item.beam && data_q.sec == ctrl_i.item.sec;
  assign merged     = (ctrl_i.item.req > data_q.req) ? ctrl_i.item.req : data_q.req;
  assign hit_req_o  = hit_o ? merged : '0;
  assign hit_zero_o = hit_o && data_q.req == '0;
  assign data_o     = data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (gt_o) begin
          data_d = prev_gt_i ? prev_i : ctrl_i.item;
        end
      end
      CMD_MERGE: begin
        if (hit_o) begin
          data_d.req = merged;
        end
      end
      CMD_CLEAR: data_d.req = '0;
      CMD_SHIFT: data_d = (is_tail_i && ctrl_i.retain) ? head_i : next_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: sv/beam_request_table.sv
// Beam request table: sorted chain of entry cells with an add, clear, discard and sync sequencer.
//
// The table keeps up to TABLE_DEPTH beam requests in a chain of cells that is always sorted by
// beam index and then section, so an add is a parallel compare in every cell followed by a merge
// (the larger sample count is kept), a rejection with a status code, or a sorted insert in which
// the cells above the insertion point each take their lower neighbour's entry. An add, clear,
// discard or unused mode is accepted in the idle state; in the exec state, once the output
// register is free, the chain acts and the result is loaded into the output register. A sync
// starts up in the exec state and, unless it has nothing to emit, then rotates the chain one entry
// per cycle through cell 0: new-set and keep syncs take one pass over the stored entries, an
// adjust sync takes two passes, the first emitting entries with a non-zero count and the second
// emitting and dropping the zero-count orphans. Each emitting step also waits for the output
// register to be free, so back-pressure on the result side can hold the rotation. The input side
// takes a new beat only while the sequencer is idle; a finished result may still be waiting in the
// output register at that time. The result beat packs entry_valid, section, beam index, sample
// count, kept count and status into tdata, with tlast on the final result of the item.
module beam_request_table
  import brt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned SECTIONS    = DefSections
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // section, beam_index, sample_request
  input  logic [2:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // entry_valid, section_res, beam_index_res,
                                     // sample_request_res, kept_count, status
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [19:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SYNC1 = 2'd2;
  localparam logic [1:0] ST_SYNC2 = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [2:0]    mode_q;
  brt_entry_t    item_q;
  logic [CW-1:0] count_q, count_d, nz_q, nz_d;
  logic [CW-1:0] steps_q, steps_d, emitted_q, emitted_d;
  logic [CW-1:0] emit_tot_q, emit_tot_d, kept_q, kept_d;
  logic [7:0]    num_sec_q;
  logic [19:0]   max_beam_q;

  logic          out_vld_q, out_vld_d, out_last_q, out_last_d;
  logic [55:0]   out_data_q;
  logic [52:0]   out_data_d;
  logic          out_free, out_load;

  brt_ctrl_t     ctrl;
  brt_entry_t    cell_data [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt, hit, hit_zero, valid, is_tail;
  logic [ReqW-1:0] hit_req [TABLE_DEPTH];
  logic [ReqW-1:0] hit_req_or;
  logic          any_hit, any_hit_zero;

  // The chain of cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign valid[i]   = count_q > CW'(i);
    assign is_tail[i] = count_q == CW'(i + 1);
    brt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (valid[i]),
      .is_tail_i  (is_tail[i]),
      .head_i     (cell_data[0]),
      .prev_i     (cell_data[(i == 0) ? 0 : i - 1]),
      .prev_gt_i  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .next_i     (cell_data[(i + 1) % TABLE_DEPTH]),
      .data_o     (cell_data[i]),
      .gt_o       (gt[i]),
      .hit_o      (hit[i]),
      .hit_zero_o (hit_zero[i]),
      .hit_req_o  (hit_req[i])
    );
  end

  always_comb begin
    hit_req_or = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_req_or = hit_req_or | hit_req[i];
    end
  end
  assign any_hit      = |hit;
  assign any_hit_zero = |hit_zero;

  assign s_axis_tready = state_q == ST_IDLE;
  assign out_free      = !out_vld_q || m_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sec_q  <= 8'd1;
      max_beam_q <= 20'hFFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_SECTIONS: num_sec_q  <= cfg_wdata_i[7:0];
        CFG_MAX_BEAM:     max_beam_q <= cfg_wdata_i;
        default:          num_sec_q  <= num_sec_q;
      endcase
    end
  end

  // Sequencer. A sync pops cell 0 every step; a retained entry goes back in at the tail, so a
  // whole pass leaves the order intact while orphans can be dropped on the way.
  logic       head_orph, step_emit, step_retain, step_go, bad_sec, bad_beam;
  logic [CW-1:0] sync_kept, sync_emit;

  always_comb begin
    head_orph = cell_data[0].req == '0;
    step_emit   = 1'b0;
    step_retain = 1'b1;
    if (state_q == ST_SYNC1) begin
      step_emit   = (mode_q == MODE_SYNC_KEEP) || !head_orph;
      step_retain = (mode_q != MODE_SYNC_NEW) || !head_orph;
    end else if (state_q == ST_SYNC2) begin
      step_emit   = head_orph;
      step_retain = !head_orph;
    end
    step_go  = !step_emit || out_free;
    bad_sec  = {1'b0, item_q.sec} >= num_sec_q || {1'b0, item_q.sec} >= 8'(SECTIONS);
    bad_beam = item_q.beam == '0 || item_q.beam > max_beam_q;
    sync_kept = (mode_q == MODE_SYNC_KEEP) ? count_q : nz_q;
    sync_emit = (mode_q == MODE_SYNC_NEW) ? nz_q : count_q;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    nz_d       = nz_q;
    steps_d    = steps_q;
    emitted_d  = emitted_q;
    emit_tot_d = emit_tot_q;
    kept_d     = kept_q;
    ctrl.cmd    = CMD_HOLD;
    ctrl.retain = step_retain;
    ctrl.item   = item_q;
    out_load   = 1'b0;
    out_last_d = 1'b1;
    out_data_d = {STAT_OK, 7'(count_q), 16'd0, 20'd0, 7'd0, 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
          case (mode_q) inside
            MODE_ADD: begin
              out_load = 1'b1;
              if (any_hit) begin
                ctrl.cmd = CMD_MERGE;
                if (any_hit_zero && item_q.req != '0) begin
                  nz_d = nz_q + 1'b1;
                end
                out_data_d = {STAT_OK, 7'(count_q), hit_req_or, item_q.beam, item_q.sec, 1'b1};
              end else if (bad_sec) begin
                out_data_d = {STAT_BAD_SEC, 7'(count_q), 16'd0, 20'd0, 7'd0, 1'b0};
              end else if (bad_beam) begin
                out_data_d = {STAT_BAD_BEAM, 7'(count_q), 16'd0, 20'd0, 7'd0, 1'b0};
              end else if (count_q >= CW'(TABLE_DEPTH)) begin
                out_data_d = {STAT_FULL, 7'(count_q), 16'd0, 20'd0, 7'd0, 1'b0};
              end else begin
                ctrl.cmd = CMD_INSERT;
                count_d  = count_q + 1'b1;
                if (item_q.req != '0) begin
                  nz_d = nz_q + 1'b1;
                end
                out_data_d = {STAT_OK, 7'(count_d), item_q.req, item_q.beam, item_q.sec, 1'b1};
              end
            end
            MODE_CLEAR: begin
              ctrl.cmd = CMD_CLEAR;
              nz_d     = '0;
              out_load = 1'b1;
            end
            MODE_DISCARD: begin
              count_d    = '0;
              nz_d       = '0;
              out_load   = 1'b1;
              out_data_d = {STAT_OK, 7'd0, 16'd0, 20'd0, 7'd0, 1'b0};
            end
            MODE_SYNC_NEW, MODE_SYNC_ADJ, MODE_SYNC_KEEP: begin
              kept_d     = sync_kept;
              emit_tot_d = sync_emit;
              if (sync_emit == '0) begin
                count_d    = sync_kept;
                out_load   = 1'b1;
                out_data_d = {STAT_OK, 7'(sync_kept), 16'd0, 20'd0, 7'd0, 1'b0};
              end else begin
                state_d   = ST_SYNC1;
                steps_d   = count_q;
                emitted_d = '0;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_SYNC1, ST_SYNC2: begin
        if (step_go) begin
          ctrl.cmd = CMD_SHIFT;
          steps_d  = steps_q - 1'b1;
          if (!step_retain) begin
            count_d = count_q - 1'b1;
          end
          if (step_emit) begin
            out_load   = 1'b1;
            emitted_d  = emitted_q + 1'b1;
            out_last_d = (emitted_q + 1'b1) == emit_tot_q;
            out_data_d = {STAT_OK, 7'(kept_q), cell_data[0].req, cell_data[0].beam,
                          cell_data[0].sec, 1'b1};
          end
          if (steps_q == CW'(1)) begin
            if (state_q == ST_SYNC1 && mode_q == MODE_SYNC_ADJ) begin
              state_d = ST_SYNC2;
              steps_d = count_q;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      nz_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      nz_q      <= nz_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q    <= steps_d;
    emitted_q  <= emitted_d;
    emit_tot_q <= emit_tot_d;
    kept_q     <= kept_d;
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tuser;
      item_q <= '{sec: s_axis_tdata[6:0], beam: s_axis_tdata[26:7], req: s_axis_tdata[42:27]};
    end
    if (out_load) begin
      out_data_q <= {3'b000, out_data_d};
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // The count of non-orphan entries can never exceed the number of entries held.
  a_nz_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni) nz_q <= count_q)
    else $error("non-orphan count exceeds entry count");

  // The chain never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The orphan pass only follows an adjust sync.
  a_sync2_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SYNC2 |-> mode_q == MODE_SYNC_ADJ)
    else $error("orphan pass outside an adjust sync");

  // A new result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |-> !out_load)
    else $error("result register overwritten");

endmodule
